// File: design/wepsu_pkg.sv
// Shared types, codes and constants for the wheel encoder position/speed unit.
`timescale 1ns / 1ps

package wepsu_pkg;

	localparam int COUNT_BITS = 16;
	localparam int ROLL_W     = 4;
	localparam int TOTAL_W    = 21;
	localparam int SPEED_W    = 21;
	localparam int ANGLE_W    = 15;
	localparam int SPAN_W     = 19;
	localparam int PART_W     = 21;
	localparam int PROD_W     = 37;
	localparam int SUM_W      = 25;
	localparam int MAG_W      = 24;
	localparam int RECIP_W    = 25;
	localparam int QPROD_W    = MAG_W + RECIP_W;
	localparam int RECIP_SH   = 34;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 19;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam logic [20:0] PART_SCALE = 21'd1525069;
	localparam logic signed [SUM_W-1:0] QUAD_SCALE = 25'sd1525092;
	localparam logic signed [SUM_W-1:0] QUAD_FULL  = 25'sd6100400;
	localparam logic signed [SUM_W-1:0] HALF_TURN  = 25'sd3141590;
	localparam logic signed [SUM_W-1:0] FULL_TURN  = 25'sd6283180;
	// ceil(2^34 / 1000): exact quotient for magnitudes below 2^34/816
	localparam logic [RECIP_W-1:0] RECIP_1000 = 25'd17179870;

	localparam logic signed [ROLL_W-1:0] ROLL_MAX  = 4'sd7;
	localparam logic signed [ROLL_W-1:0] ROLL_MIN  = -4'sd8;
	localparam logic signed [ROLL_W-1:0] ROLL_FULL = 4'sd4;

	localparam logic [SPAN_W-1:0]     RST_WRAP_SPAN = 19'd271000;
	localparam logic [COUNT_BITS-1:0] RST_CW_COUNT  = 16'd8856;
	localparam logic signed [ROLL_W-1:0] RST_CW_WRAPS = 4'sd4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WRAP_SPAN = 2'd0,
		CFG_CW_COUNT  = 2'd1,
		CFG_CW_WRAPS  = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_ROLLOVER = 2'd0,
		MODE_INDEX    = 2'd1,
		MODE_TICK     = 2'd2,
		MODE_QUERY    = 2'd3
	} mode_t;

	// classified item handed from front to back
	typedef struct packed {
		mode_t                     mode;
		logic [COUNT_BITS-1:0]     pos;
		logic signed [ROLL_W-1:0]  roll;
		logic [COUNT_BITS-1:0]     load;
	} cmd_t;

	typedef struct packed {
		logic [SPEED_W-1:0]    speed;
		logic [ANGLE_W-1:0]    angle;
		logic [COUNT_BITS-1:0] load;
		logic                  load_en;
	} res_t;

	// quarter-turn offset in microradians for a rollover count
	function automatic logic signed [SUM_W-1:0] quad_urad(input logic signed [ROLL_W-1:0] r);
		logic signed [SUM_W-1:0] rx;
		rx = SUM_W'(r);
		if (r >= ROLL_FULL) begin
			return QUAD_FULL;
		end
		return SUM_W'(rx * QUAD_SCALE);
	endfunction

endpackage

// File: design/wepsu_front.sv
// Front end: accepts items, tracks the rollover count and classifies each item.
`timescale 1ns / 1ps

module wepsu_front import wepsu_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     accept,
	input  mode_t                    mode,
	input  logic                     count_up,
	input  logic                     direction_ccw,
	input  logic [COUNT_BITS-1:0]    position_count,
	input  logic [COUNT_BITS-1:0]    cw_index_count,
	input  logic signed [ROLL_W-1:0] cw_index_wraps,
	output cmd_t                     cmd
);

	logic signed [ROLL_W-1:0] roll_q;
	logic signed [ROLL_W-1:0] roll_next;

	always_comb begin
		roll_next = roll_q;
		cmd.mode  = mode;
		cmd.pos   = position_count;
		cmd.roll  = roll_q;
		cmd.load  = '0;
		case (mode)
			MODE_ROLLOVER: begin
				if (count_up && roll_q != ROLL_MAX) begin
					roll_next = roll_q + 4'sd1;
				end else if (!count_up && roll_q != ROLL_MIN) begin
					roll_next = roll_q - 4'sd1;
				end
			end
			MODE_INDEX: begin
				if (direction_ccw) begin
					roll_next = '0;
				end else begin
					roll_next = cw_index_wraps;
					cmd.load  = cw_index_count;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_q <= '0;
		end else if (accept) begin
			roll_q <= roll_next;
		end
	end

endmodule

// File: design/wepsu_fifo.sv
// Short queue between front and back ends.
`timescale 1ns / 1ps

module wepsu_fifo import wepsu_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	cmd_t             mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign valid    = (count_q != '0);
	assign pop_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: design/wepsu_back.sv
// Back end: pipelined speed and angle arithmetic with the output register.
`timescale 1ns / 1ps

module wepsu_back import wepsu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  cmd_t              in_cmd,
	input  logic [SPAN_W-1:0] wrap_span,
	output logic              out_valid,
	input  logic              out_ready,
	output res_t              out_res
);

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, out_valid_q;
	logic adv1, adv2, adv3, adv4, adv5, adv_out;

	mode_t mode_s1, mode_s2, mode_s3, mode_s4, mode_s5;
	logic [COUNT_BITS-1:0] load_s1, load_s2, load_s3, load_s4, load_s5;

	logic [TOTAL_W-1:0]       total_s1;
	logic [PROD_W-1:0]        prod_s1;
	logic signed [SUM_W-1:0]  quad_s1;
	logic signed [TOTAL_W:0]  diff_s2;
	logic [PART_W-1:0]        part_s2;
	logic signed [SUM_W-1:0]  quad_s2;
	logic [SPEED_W-1:0]       speed_s3, speed_s4, speed_s5;
	logic signed [SUM_W-1:0]  sum_s3;
	logic                     neg_s4, neg_s5;
	logic [MAG_W-1:0]         mag_s4;
	logic [QPROD_W-1:0]       qprod_s5;
	logic [TOTAL_W-1:0]       last_total_q;
	res_t                     res_q;

	// stage 1 logic
	logic signed [TOTAL_W-1:0] roll_x;
	logic [TOTAL_W-1:0]        total_d;
	// stage 2 logic
	logic [PART_W-1:0]         div_a;
	logic [PART_W:0]           div_ab;
	logic [5:0]                div_c;
	logic [COUNT_BITS:0]       div_cd;
	logic [PART_W:0]           part_d;
	// stage 3 logic
	logic signed [TOTAL_W:0]   half_x, span_x, speed_d;
	logic signed [SUM_W-1:0]   sum_d;
	// output logic
	logic [ANGLE_W-1:0]        quo;

	assign adv_out  = !out_valid_q || out_ready;
	assign adv5     = !valid_s5 || adv_out;
	assign adv4     = !valid_s4 || adv5;
	assign adv3     = !valid_s3 || adv4;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

	// total = pos + 65535 * roll, kept to 21 bits
	always_comb begin
		roll_x  = TOTAL_W'(in_cmd.roll);
		total_d = TOTAL_W'(in_cmd.pos) + {roll_x[TOTAL_W-COUNT_BITS-1:0], {COUNT_BITS{1'b0}}}
			- roll_x;
	end

	// floor(x / 65535): x = 65535*a + (a + b), folded once more
	always_comb begin
		div_a  = prod_s1[PROD_W-1:COUNT_BITS];
		div_ab = (PART_W + 1)'(div_a) + (PART_W + 1)'(prod_s1[COUNT_BITS-1:0]);
		div_c  = div_ab[PART_W:COUNT_BITS];
		div_cd = (COUNT_BITS + 1)'(div_c) + (COUNT_BITS + 1)'(div_ab[COUNT_BITS-1:0]);
		part_d = (PART_W + 1)'(div_a) + (PART_W + 1)'(div_c)
			+ (PART_W + 1)'(div_cd >= (COUNT_BITS + 1)'(COUNT_MAX));
	end

	// single wrap correction on the speed, angle sum above a half turn less one full turn
	always_comb begin
		span_x  = (TOTAL_W + 1)'(wrap_span);
		half_x  = (TOTAL_W + 1)'(wrap_span[SPAN_W-1:1]);
		speed_d = diff_s2;
		if (!diff_s2[TOTAL_W]) begin
			if (diff_s2 >= half_x) begin
				speed_d = diff_s2 - span_x;
			end
		end else if (diff_s2 < -half_x) begin
			speed_d = diff_s2 + span_x;
		end
		sum_d = SUM_W'(part_s2) + quad_s2;
		if (sum_d > HALF_TURN) begin
			sum_d = sum_d - FULL_TURN;
		end
	end

	assign quo = ANGLE_W'(qprod_s5[QPROD_W-1:RECIP_SH]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			valid_s4     <= 1'b0;
			valid_s5     <= 1'b0;
			out_valid_q  <= 1'b0;
			last_total_q <= '0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
			if (adv5) valid_s5 <= valid_s4;
			if (adv_out) out_valid_q <= valid_s5;
			if (adv2 && valid_s1 && mode_s1 == MODE_TICK) begin
				last_total_q <= total_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			mode_s1  <= in_cmd.mode;
			load_s1  <= in_cmd.load;
			total_s1 <= total_d;
			prod_s1  <= PROD_W'(in_cmd.pos) * PROD_W'(PART_SCALE);
			quad_s1  <= quad_urad(in_cmd.roll);
		end
		if (adv2) begin
			mode_s2 <= mode_s1;
			load_s2 <= load_s1;
			diff_s2 <= {total_s1[TOTAL_W-1], total_s1}
				- {last_total_q[TOTAL_W-1], last_total_q};
			part_s2 <= part_d[PART_W-1:0];
			quad_s2 <= quad_s1;
		end
		if (adv3) begin
			mode_s3  <= mode_s2;
			load_s3  <= load_s2;
			speed_s3 <= speed_d[SPEED_W-1:0];
			sum_s3   <= sum_d;
		end
		if (adv4) begin
			mode_s4  <= mode_s3;
			load_s4  <= load_s3;
			speed_s4 <= speed_s3;
			neg_s4   <= sum_s3[SUM_W-1];
			mag_s4   <= sum_s3[SUM_W-1] ? MAG_W'(-sum_s3) : MAG_W'(sum_s3);
		end
		if (adv5) begin
			mode_s5  <= mode_s4;
			load_s5  <= load_s4;
			speed_s5 <= speed_s4;
			neg_s5   <= neg_s4;
			qprod_s5 <= QPROD_W'(mag_s4) * QPROD_W'(RECIP_1000);
		end
		if (adv_out) begin
			res_q.speed   <= (mode_s5 == MODE_TICK) ? speed_s5 : '0;
			res_q.angle   <= (mode_s5 != MODE_QUERY) ? '0 : (neg_s5 ? -quo : quo);
			res_q.load    <= (mode_s5 == MODE_INDEX) ? load_s5 : '0;
			res_q.load_en <= (mode_s5 == MODE_INDEX);
		end
	end

endmodule

// File: design/wheel_encoder_position_speed_unit.sv
// Path: an accepted item passes the queue, back stages s1 to s5 and the output register.
// Throughput: one item per cycle while m_axis_tready is high; the back pipeline and
// the queue between front and back keep that rate. Under an output stall the queue and
// the six back registers hold FIFO_DEPTH + 6 items before tready drops.
// Reset (arst_n low, asynchronous): rollover count and last total cleared, queue and
// pipeline emptied, config registers back to wrap span 271000, preset 8856 and 4 wraps.
`timescale 1ns / 1ps

module wheel_encoder_position_speed_unit import wepsu_pkg::*; #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// [0] count_up, [1] direction_ccw, [17:2] position_count, [23:18] zero
	input  logic [23:0]           s_axis_tdata,
	// [1:0] mode
	input  logic [1:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [20:0] speed_counts, [35:21] angle_mrad, [51:36] counter_load, [55:52] zero
	output logic [55:0]           m_axis_tdata,
	// [0] load_enable
	output logic                  m_axis_tuser,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	logic [SPAN_W-1:0]        wrap_span_q;
	logic [COUNT_BITS-1:0]    cw_count_q;
	logic signed [ROLL_W-1:0] cw_wraps_q;

	logic accept, fifo_full, fifo_valid, fifo_pop;
	cmd_t front_cmd, fifo_cmd;
	res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_span_q <= RST_WRAP_SPAN;
			cw_count_q  <= RST_CW_COUNT;
			cw_wraps_q  <= RST_CW_WRAPS;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_WRAP_SPAN: wrap_span_q <= wr_data[SPAN_W-1:0];
				CFG_CW_COUNT:  cw_count_q  <= wr_data[COUNT_BITS-1:0];
				CFG_CW_WRAPS:  cw_wraps_q  <= wr_data[ROLL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign s_axis_tready = !fifo_full;
	assign accept        = s_axis_tvalid && s_axis_tready;

	wepsu_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.mode           (mode_t'(s_axis_tuser)),
		.count_up       (s_axis_tdata[0]),
		.direction_ccw  (s_axis_tdata[1]),
		.position_count (s_axis_tdata[17:2]),
		.cw_index_count (cw_count_q),
		.cw_index_wraps (cw_wraps_q),
		.cmd            (front_cmd)
	);

	wepsu_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (front_cmd),
		.full      (fifo_full),
		.pop       (fifo_pop),
		.valid     (fifo_valid),
		.pop_data  (fifo_cmd)
	);

	logic back_ready;

	assign fifo_pop = fifo_valid && back_ready;

	wepsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fifo_valid),
		.in_ready  (back_ready),
		.in_cmd    (fifo_cmd),
		.wrap_span (wrap_span_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {4'b0, res.load, res.angle, res.speed};
	assign m_axis_tuser = res.load_en;

endmodule
